### sv/mwsg_pkg.sv
package mwsg_pkg;

    // Phase table geometry: one period of the waveform in table points.
    localparam int unsigned TABLE_SIZE = 256;
    localparam int unsigned PHASE_W    = $clog2(TABLE_SIZE);
    localparam int unsigned QUARTER    = TABLE_SIZE / 4;
    localparam int unsigned QTR_W      = $clog2(QUARTER) + 1;

    // Output code range and waveform constants.
    localparam int unsigned SAMPLE_W   = 12;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] SINE_MID   = 12'd2000;
    localparam int unsigned SINE_AMP_W = 11;

    // DC scaling: 4095/3300 = 273/220, realized as (mv * DC_RECIP) >> DC_SHIFT.
    // The reciprocal is rounded up; the error stays below 1/220 for any 12-bit input,
    // so the truncated product equals the exact floor.
    localparam int unsigned DC_MV_W    = 12;
    localparam int unsigned DC_SHIFT   = 20;
    localparam int unsigned DC_RECIP_W = 21;
    localparam logic [DC_RECIP_W-1:0] DC_RECIP = 21'd1301188;

    localparam int unsigned DUTY_W     = 9;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_MV     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY      = 2'd2;

    // Waveform selector codes.
    typedef enum logic [2:0] {
        WAVE_DC       = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_SAWTOOTH = 3'd3,
        WAVE_SINE     = 3'd4
    } t_wave_mode;

    localparam logic [DUTY_W-1:0] DUTY_RESET = 9'd128;

    // Quarter-wave sine magnitude: floor(1800 * sin(pi/2 * rr / 64)), rr = 0..64.
    function automatic logic [SINE_AMP_W-1:0] sine_quarter(input logic [QTR_W-1:0] rr);
        logic [SINE_AMP_W-1:0] m;
        begin
            case (rr)
                7'd0:  m = 11'd0;
                7'd1:  m = 11'd44;
                7'd2:  m = 11'd88;
                7'd3:  m = 11'd132;
                7'd4:  m = 11'd176;
                7'd5:  m = 11'd220;
                7'd6:  m = 11'd264;
                7'd7:  m = 11'd307;
                7'd8:  m = 11'd351;
                7'd9:  m = 11'd394;
                7'd10: m = 11'd437;
                7'd11: m = 11'd480;
                7'd12: m = 11'd522;
                7'd13: m = 11'd564;
                7'd14: m = 11'd606;
                7'd15: m = 11'd647;
                7'd16: m = 11'd688;
                7'd17: m = 11'd729;
                7'd18: m = 11'd769;
                7'd19: m = 11'd809;
                7'd20: m = 11'd848;
                7'd21: m = 11'd887;
                7'd22: m = 11'd925;
                7'd23: m = 11'd962;
                7'd24: m = 11'd1000;
                7'd25: m = 11'd1036;
                7'd26: m = 11'd1072;
                7'd27: m = 11'd1107;
                7'd28: m = 11'd1141;
                7'd29: m = 11'd1175;
                7'd30: m = 11'd1208;
                7'd31: m = 11'd1241;
                7'd32: m = 11'd1272;
                7'd33: m = 11'd1303;
                7'd34: m = 11'd1333;
                7'd35: m = 11'd1362;
                7'd36: m = 11'd1391;
                7'd37: m = 11'd1419;
                7'd38: m = 11'd1445;
                7'd39: m = 11'd1471;
                7'd40: m = 11'd1496;
                7'd41: m = 11'd1520;
                7'd42: m = 11'd1543;
                7'd43: m = 11'd1566;
                7'd44: m = 11'd1587;
                7'd45: m = 11'd1607;
                7'd46: m = 11'd1627;
                7'd47: m = 11'd1645;
                7'd48: m = 11'd1662;
                7'd49: m = 11'd1679;
                7'd50: m = 11'd1694;
                7'd51: m = 11'd1709;
                7'd52: m = 11'd1722;
                7'd53: m = 11'd1734;
                7'd54: m = 11'd1746;
                7'd55: m = 11'd1756;
                7'd56: m = 11'd1765;
                7'd57: m = 11'd1773;
                7'd58: m = 11'd1780;
                7'd59: m = 11'd1786;
                7'd60: m = 11'd1791;
                7'd61: m = 11'd1795;
                7'd62: m = 11'd1797;
                7'd63: m = 11'd1799;
                7'd64: m = 11'd1800;
                default: m = 11'd0;
            endcase
            return m;
        end
    endfunction

endpackage

### sv/multi_waveform_sample_generator.sv
// Multi-waveform DAC sample generator.
// Each request on the slave stream is one sample tick; bit 0 of its tdata is the
// restart flag, which sets the phase index to zero before the sample is computed.
// Each request gives exactly one result on the master stream: the 12-bit DAC code
// and the phase index it was computed for, with tlast marking the final point of
// the 256-point period. The phase then advances and wraps after the last point.
// The wave (dc, triangle, square, sawtooth, sine), the dc level in millivolts and
// the square-wave duty count are set through the register write port; the user must
// write them only while the stream is idle, which the block itself does not enforce.
// An accepted request gives a valid result in the next cycle, held in a single
// output register. Throughput is one request per cycle: the slave side is ready
// whenever the output register is empty or is being drained in the same cycle.
// If the receiver stalls, the result waits in the output register and the slave
// side stops taking requests until it is taken.
// Reset (synchronous, active low) empties the output register, sets the phase
// index to zero and loads the register defaults: dc mode, 0 mV, duty count 128.
module multi_waveform_sample_generator
    import mwsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Sample tick requests
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [0] restart, [7:1] zero
    // Sample results
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [23:0]           o_m_tdata,   // [11:0] sample, [19:12] phase_index, [23:20] zero
    output logic                  o_m_tlast    // period_end
);

    logic [2:0]          r_wave_mode;
    logic [DC_MV_W-1:0]  r_dc_mv;
    logic [DUTY_W-1:0]   r_duty;
    logic [PHASE_W-1:0]  r_phase;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [PHASE_W-1:0]  r_out_phase;
    logic                r_out_last;

    logic                s_accept;
    logic [PHASE_W-1:0]  cur_idx;
    logic                cur_last;
    logic [PHASE_W-1:0]  n_phase;
    logic [SAMPLE_W-1:0] n_sample;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= WAVE_DC;
            r_dc_mv     <= '0;
            r_duty      <= DUTY_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_WAVE_MODE: r_wave_mode <= i_cfg_wdata[2:0];
                CFG_DC_MV:     r_dc_mv     <= i_cfg_wdata[DC_MV_W-1:0];
                CFG_DUTY:      r_duty      <= i_cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: accept whenever the output register is free or being drained.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Phase index for this request and the index that follows it.
    assign cur_idx  = i_s_tdata[0] ? '0 : r_phase;
    assign cur_last = (cur_idx == PHASE_W'(TABLE_SIZE - 1));
    assign n_phase  = cur_last ? '0 : cur_idx + 1'b1;

    // DC level: floor(4095 * mv / 3300) by reciprocal multiply, then saturate.
    logic [DC_MV_W+DC_RECIP_W-1:0] dc_prod;
    logic [DC_MV_W+DC_RECIP_W-DC_SHIFT-1:0] dc_code;
    logic [SAMPLE_W-1:0] dc_sample;
    assign dc_prod   = {{DC_RECIP_W{1'b0}}, r_dc_mv} * {{DC_MV_W{1'b0}}, DC_RECIP};
    assign dc_code   = dc_prod[DC_MV_W+DC_RECIP_W-1:DC_SHIFT];
    assign dc_sample = (dc_code > {1'b0, FULL_SCALE}) ? FULL_SCALE : dc_code[SAMPLE_W-1:0];

    // Triangle: i*8190 = i*8192 - 2*i; rising half floors, falling half uses a ceiling.
    localparam int unsigned TRI_W = PHASE_W + 13;
    logic [TRI_W-1:0]  tri_prod;
    logic [TRI_W-1:0]  tri_ceil;
    logic [12:0]       tri_fall;
    logic [SAMPLE_W-1:0] tri_sample;
    assign tri_prod = {cur_idx, 13'd0} - {{(TRI_W-PHASE_W-1){1'b0}}, cur_idx, 1'b0};
    assign tri_ceil = tri_prod + TRI_W'(TABLE_SIZE - 1);
    assign tri_fall = 13'd8190 - tri_ceil[TRI_W-1:PHASE_W];
    always_comb begin
        if (!cur_idx[PHASE_W-1]) begin
            tri_sample = tri_prod[PHASE_W+SAMPLE_W-1:PHASE_W];
        end else if (tri_fall > {1'b0, FULL_SCALE}) begin
            tri_sample = FULL_SCALE;
        end else begin
            tri_sample = tri_fall[SAMPLE_W-1:0];
        end
    end

    // Sawtooth: floor(i*4095 / N) with i*4095 = i*4096 - i.
    localparam int unsigned SAW_W = PHASE_W + SAMPLE_W;
    logic [SAW_W-1:0]    saw_prod;
    logic [SAMPLE_W-1:0] saw_sample;
    assign saw_prod   = {cur_idx, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, cur_idx};
    assign saw_sample = saw_prod[SAW_W-1:PHASE_W];

    // Sine: quarter-wave table folded by quadrant; the lower half rounds down.
    logic [1:0]            sin_quad;
    logic [QTR_W-1:0]      sin_rr;
    logic [SINE_AMP_W-1:0] sin_mag;
    logic                  sin_exact;
    logic [SAMPLE_W-1:0]   sin_sample;
    assign sin_quad  = cur_idx[PHASE_W-1:PHASE_W-2];
    assign sin_rr    = sin_quad[0] ? QTR_W'(QUARTER) - {1'b0, cur_idx[PHASE_W-3:0]}
                                   : {1'b0, cur_idx[PHASE_W-3:0]};
    assign sin_mag   = sine_quarter(sin_rr);
    assign sin_exact = (sin_rr == '0) || (sin_rr == QTR_W'(QUARTER));
    assign sin_sample = sin_quad[1]
        ? SINE_MID - {1'b0, sin_mag} - {{(SAMPLE_W-1){1'b0}}, !sin_exact}
        : SINE_MID + {1'b0, sin_mag};

    // Wave selection; unused codes give zero.
    always_comb begin
        case (r_wave_mode)
            WAVE_DC:       n_sample = dc_sample;
            WAVE_TRIANGLE: n_sample = tri_sample;
            WAVE_SQUARE:   n_sample = ({1'b0, cur_idx} < r_duty) ? FULL_SCALE : '0;
            WAVE_SAWTOOTH: n_sample = saw_sample;
            WAVE_SINE:     n_sample = sin_sample;
            default:       n_sample = '0;
        endcase
    end

    // Phase counter and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_sample <= n_sample;
            r_out_phase  <= cur_idx;
            r_out_last   <= cur_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_phase, r_out_sample};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTH
    // A restart request always yields a result for index zero.
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tdata[0]) |=> (o_m_tvalid && r_out_phase == '0))
        else $error("restart did not produce index zero");

    // The period-end flag marks exactly the last table index.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (r_out_phase == PHASE_W'(TABLE_SIZE - 1))))
        else $error("period end flag does not match phase index");

    // After each request the stored phase is the successor of the reported one.
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_out_last ? (r_phase == '0) : (r_phase == r_out_phase + 1'b1)))
        else $error("phase counter did not advance from the reported index");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mwsg_pkg::*;

    localparam int unsigned TOTAL_TICKS = 1950;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned DIR_ROWS    = 29;
    localparam real         HALF_PI     = 1.5707963267948966;

    // A selector code that names no waveform; the block must output zero for it.
    localparam logic [2:0] WAVE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] code;
        logic [PHASE_W-1:0]  phase_idx;
        logic                period_end;
    } t_dac_result;

    typedef struct packed {
        logic        valid;
        t_dac_result res;
    } t_tick_check;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_TICK_CHK
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  restart;
        t_dac_result           want;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
    } t_dir_row;

    // Block ports.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [23:0]           o_m_tdata;
    logic                  o_m_tlast;

    // Shadow copy of the block's registers and phase counter.
    logic [2:0]            wave_sel    = WAVE_DC;
    logic [DC_MV_W-1:0]    dc_level_mv = '0;
    logic [DUTY_W-1:0]     duty_high   = DUTY_RESET;
    logic [PHASE_W-1:0]    next_phase  = '0;

    t_dac_result pending_codes [$];
    t_tick_check fixed_results [$];

    int unsigned ticks_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned period_ends   = 0;
    int unsigned restarts_seen = 0;
    int unsigned settings_run  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned rx_stall_left = 0;
    bit          quiet         = 1'b0;

    // Directed rows: reset values, dc extremes, square duty extremes, each wave
    // from a restart, and an unused selector code.
    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{ROW_TICK_CHK, 1'b0, '{12'd0,    8'd0, 1'b0}, '0, '0},
        '{ROW_TICK_CHK, 1'b0, '{12'd0,    8'd1, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_DC_MV, 12'd3300},
        '{ROW_TICK_CHK, 1'b1, '{12'd4095, 8'd0, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_DC_MV, 12'd4095},
        '{ROW_TICK_CHK, 1'b0, '{12'd4095, 8'd1, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_DC_MV, 12'd1650},
        '{ROW_TICK_CHK, 1'b0, '{12'd2047, 8'd2, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_WAVE_MODE, CFG_DATA_W'(WAVE_SQUARE)},
        '{ROW_TICK_CHK, 1'b1, '{12'd4095, 8'd0, 1'b0}, '0, '0},
        '{ROW_TICK,     1'b0, '0, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_DUTY, 12'd0},
        '{ROW_TICK_CHK, 1'b0, '{12'd0,    8'd2, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_DUTY, 12'd256},
        '{ROW_TICK_CHK, 1'b0, '{12'd4095, 8'd3, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_DUTY, 12'd511},
        '{ROW_TICK_CHK, 1'b0, '{12'd4095, 8'd4, 1'b0}, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_WAVE_MODE, CFG_DATA_W'(WAVE_TRIANGLE)},
        '{ROW_TICK_CHK, 1'b1, '{12'd0,    8'd0, 1'b0}, '0, '0},
        '{ROW_TICK,     1'b0, '0, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_WAVE_MODE, CFG_DATA_W'(WAVE_SAWTOOTH)},
        '{ROW_TICK_CHK, 1'b1, '{12'd0,    8'd0, 1'b0}, '0, '0},
        '{ROW_TICK,     1'b0, '0, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_WAVE_MODE, CFG_DATA_W'(WAVE_SINE)},
        '{ROW_TICK_CHK, 1'b1, '{12'd2000, 8'd0, 1'b0}, '0, '0},
        '{ROW_TICK,     1'b0, '0, '0, '0},
        '{ROW_CFG,      1'b0, '0, CFG_WAVE_MODE, CFG_DATA_W'(WAVE_UNUSED_HI)},
        '{ROW_TICK_CHK, 1'b0, '{12'd0,    8'd2, 1'b0}, '0, '0},
        '{ROW_TICK,     1'b1, '0, '0, '0}
    };

    multi_waveform_sample_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle length: picked from three ranges, mostly the shortest, sometimes the middle one, rarely the longest.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 15) return $urandom_range(1, 3);
        if (pick < 19) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // Sine code for one table point, folded onto a quarter wave. Below the
    // midline the exact floor is one lower unless the magnitude is an integer.
    function automatic logic [SAMPLE_W-1:0] sine_code(input logic [PHASE_W-1:0] idx);
        logic [1:0]  quad;
        logic [6:0]  rr;
        int unsigned mag;
        logic        exact;
        quad  = idx[7:6];
        rr    = quad[0] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
        exact = (rr == 7'd0) || (rr == 7'd64);
        if (rr == 7'd0)
            mag = 0;
        else if (rr == 7'd64)
            mag = 1800;
        else
            mag = $rtoi($floor(1800.0 * $sin(HALF_PI * rr / 64.0)));
        if (!quad[1])
            return SAMPLE_W'(SINE_MID + mag);
        return SAMPLE_W'(SINE_MID - mag - (exact ? 0 : 1));
    endfunction

    // DAC code for one table point under the current register settings.
    function automatic logic [SAMPLE_W-1:0] predict_code(input logic [PHASE_W-1:0] idx);
        int unsigned pt;
        int unsigned v;
        pt = idx;
        case (wave_sel)
            WAVE_DC: begin
                v = (FULL_SCALE * dc_level_mv) / 3300;
            end
            WAVE_TRIANGLE: begin
                if (pt < TABLE_SIZE / 2)
                    v = (pt * 2 * FULL_SCALE) / TABLE_SIZE;
                else
                    v = 2 * FULL_SCALE - (pt * 2 * FULL_SCALE + TABLE_SIZE - 1) / TABLE_SIZE;
            end
            WAVE_SQUARE: begin
                v = (pt < duty_high) ? FULL_SCALE : 0;
            end
            WAVE_SAWTOOTH: begin
                v = (pt * FULL_SCALE) / TABLE_SIZE;
            end
            WAVE_SINE: begin
                v = 32'(sine_code(idx));
            end
            default: begin
                v = 0;
            end
        endcase
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return v[SAMPLE_W-1:0];
    endfunction

    // One register write; the shadow copy follows at the write edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_WAVE_MODE: wave_sel    = val[2:0];
            CFG_DC_MV:     dc_level_mv = val[DC_MV_W-1:0];
            CFG_DUTY:      duty_high   = val[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample tick request after a random gap and wait for it to be taken.
    task automatic push_tick(input logic restart, input logic checked, input t_dac_result fixed);
        int unsigned gap;
        t_tick_check entry;
        gap = quiet ? 0 : (($urandom_range(0, 2) == 0) ? idle_len() : 0);
        entry.valid = checked;
        entry.res   = fixed;
        fixed_results.push_back(entry);
        i_cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!o_s_tready);
        ticks_sent++;
    endtask

    // Stop requesting and wait until every sent tick has produced its result.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (results_seen < ticks_sent) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Result side: random stalls, switched off during quiet stretches.
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_stall_left = idle_len() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Scoreboard: check results against the oldest expectation, then predict
    // the result of a newly accepted request.
    always @(posedge i_clk) begin : scoreboard
        t_dac_result got;
        t_dac_result want;
        t_tick_check row;
        logic [PHASE_W-1:0] idx;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.code       = o_m_tdata[11:0];
                got.phase_idx  = o_m_tdata[19:12];
                got.period_end = o_m_tlast;
                results_seen++;
                if (pending_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: code %0d index %0d end %0b",
                                 got.code, got.phase_idx, got.period_end);
                end else begin
                    want = pending_codes.pop_front();
                    if (got.code !== want.code || got.phase_idx !== want.phase_idx ||
                        got.period_end !== want.period_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: code %0d/%0d index %0d/%0d end %0b/%0b (exp/act)",
                                     want.code, got.code, want.phase_idx, got.phase_idx,
                                     want.period_end, got.period_end);
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                if (i_s_tdata[0]) begin
                    next_phase = '0;
                    restarts_seen++;
                end
                idx             = next_phase;
                want.code       = predict_code(idx);
                want.phase_idx  = idx;
                want.period_end = (idx == TABLE_SIZE - 1);
                next_phase      = idx + 1'b1;
                if (want.period_end)
                    period_ends++;
                if (fixed_results.size() != 0) begin
                    row = fixed_results.pop_front();
                    if (row.valid)
                        want = row.res;
                end
                pending_codes.push_back(want);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random register settings with
    // bursts of ticks.
    initial begin
        logic [2:0]            mode_pick;
        logic [CFG_DATA_W-1:0] dc_pick;
        logic [CFG_DATA_W-1:0] duty_pick;
        int unsigned           burst;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_tbl[k].cfg_idx, dir_tbl[k].cfg_val);
            end else begin
                push_tick(dir_tbl[k].restart, dir_tbl[k].kind == ROW_TICK_CHK, dir_tbl[k].want);
            end
        end

        while (ticks_sent < TOTAL_TICKS) begin
            drain_results();
            // Walk every selector code once, then pick at random.
            if (settings_run < 8)
                mode_pick = settings_run[2:0];
            else
                mode_pick = 3'($urandom_range(WAVE_DC, WAVE_UNUSED_HI));
            case ($urandom_range(0, 3))
                0:       dc_pick = 12'd0;
                1:       dc_pick = 12'd3300;
                2:       dc_pick = 12'd4095;
                default: dc_pick = CFG_DATA_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 4))
                0:       duty_pick = 12'd0;
                1:       duty_pick = CFG_DATA_W'(TABLE_SIZE);
                2:       duty_pick = CFG_DATA_W'(TABLE_SIZE - 1);
                3:       duty_pick = 12'd511;
                default: duty_pick = CFG_DATA_W'($urandom_range(0, 511));
            endcase
            write_reg(CFG_WAVE_MODE, {9'd0, mode_pick});
            write_reg(CFG_DC_MV, dc_pick);
            write_reg(CFG_DUTY, duty_pick);
            settings_run++;
            quiet = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(20, 300);
            if (burst > TOTAL_TICKS - ticks_sent)
                burst = TOTAL_TICKS - ticks_sent;
            repeat (burst) push_tick($urandom_range(0, 63) == 0, 1'b0, '0);
            quiet = 1'b0;
        end

        drain_results();
        if (pending_codes.size() != 0)
            mismatches++;

        $display("Ran %0d sample ticks under %0d random register settings plus directed rows.",
                 ticks_sent, settings_run);
        $display("Saw %0d period ends and %0d restarts; %0d mismatches.",
                 period_ends, restarts_seen, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/mwsg_pkg.sv
sv/multi_waveform_sample_generator.sv
sim/tb_top.sv
